/* rtl/core/oda_pkg.sv */
`default_nettype none

package oda_pkg;

    // field widths
    localparam int unsigned POS_W      = 32;
    localparam int unsigned MILEAGE_W  = 48;
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 48;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAVE_PERIOD    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DISTANCE = 8'd1;

    // reset values
    localparam logic [INTERVAL_W-1:0] SAVE_PERIOD_RST = 16'd500;
    localparam logic [INTERVAL_W-1:0] STEP_COUNT_RST  = 16'd1;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } pos_in_t;

    typedef struct packed {
        logic [MILEAGE_W-1:0] mileage;
        logic                 save_now;
    } mil_out_t;

    // |a - b| with the difference clamped to the signed 32-bit range
    function automatic logic [POS_W-1:0] sat_abs_diff(
        input logic signed [POS_W-1:0] a,
        input logic signed [POS_W-1:0] b
    );
        logic signed [POS_W:0] d;
        logic        [POS_W:0] mag;
        begin
            d   = {a[POS_W-1], a} - {b[POS_W-1], b};
            mag = d[POS_W] ? (~d + 1'b1) : d;
            if (!d[POS_W] && d[POS_W-1]) begin
                sat_abs_diff = {1'b0, {(POS_W-1){1'b1}}};
            end else if (d[POS_W] && !d[POS_W-1]) begin
                sat_abs_diff = {1'b1, {(POS_W-1){1'b0}}};
            end else begin
                sat_abs_diff = mag[POS_W-1:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/odometry_distance_accumulator.sv */
`default_nettype none

// channel | ports                                        | payload
// --------+----------------------------------------------+---------------------------------
// input   | s_valid / s_ready / s_data                   | pos_in_t: pos_x, pos_y, pos_z
// result  | m_valid / m_ready / m_data                   | mil_out_t: mileage, save_now
// config  | cfg_valid / cfg_ready / cfg_index / cfg_data | 0 save period, 1 start distance
//
// counted sample: |dx|, |dy| registered at its transfer, then squaring in ST_MUL
//   (step count remainder found alongside), square root in ST_SQRT, add in ST_ACC
// m_valid rises as ST_ACC returns to ST_IDLE; s_ready comes back with it
// a sample over an all-zero last position only stores it, ready the next cycle
// aresetn is synchronous, active low; no clearing pass is needed
// a result waits in the output register; only the add cycle stalls behind it

module odometry_distance_accumulator
    import oda_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire pos_in_t               s_data,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output mil_out_t                   m_data,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_ACC
    } state_t;

    localparam int unsigned SQ_W   = 2 * POS_W;      // dx^2 + dy^2
    localparam int unsigned REM_W  = POS_W + 2;      // sqrt partial remainder
    localparam int unsigned CNT_W  = $clog2(POS_W);  // 32 steps per phase

    // control and state
    state_t                 state_reg,    state_next;
    logic [CNT_W-1:0]       cnt_reg,      cnt_next;
    logic                   m_valid_reg,  m_valid_next;
    mil_out_t               out_reg,      out_next;

    logic [POS_W-1:0]       prev_x_reg,   prev_x_next;
    logic [POS_W-1:0]       prev_y_reg,   prev_y_next;
    logic [POS_W-1:0]       prev_z_reg,   prev_z_next;
    logic [MILEAGE_W-1:0]   total_reg,    total_next;
    logic [INTERVAL_W-1:0]  step_cnt_reg, step_cnt_next;
    logic [INTERVAL_W-1:0]  save_int_reg, save_int_next;

    // datapath
    logic [POS_W-1:0]       ax_reg,       ax_next;      // multiplicand |dx|
    logic [POS_W-1:0]       ay_reg,       ay_next;      // multiplicand |dy|
    logic [POS_W-1:0]       mx_reg,       mx_next;      // |dx| bits, msb first
    logic [POS_W-1:0]       my_reg,       my_next;      // |dy| bits, msb first
    logic [SQ_W-1:0]        acc_reg,      acc_next;     // sum of squares / radicand
    logic [POS_W-1:0]       root_reg,     root_next;
    logic [REM_W-1:0]       rem_reg,      rem_next;
    logic [INTERVAL_W-1:0]  sc_sh_reg,    sc_sh_next;   // step count bits, msb first
    logic [INTERVAL_W-1:0]  div_reg,      div_next;     // effective interval
    logic [INTERVAL_W-1:0]  mod_reg,      mod_next;     // running remainder

    logic                   in_xfer;
    logic                   out_xfer;
    logic                   prev_zero;
    logic [SQ_W-1:0]        pp_x;
    logic [SQ_W-1:0]        pp_y;
    logic [REM_W+1:0]       rem_sh;
    logic [REM_W+1:0]       trial;
    logic [INTERVAL_W:0]    mod_sh;
    logic [MILEAGE_W:0]     sum;
    logic                   save;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    assign in_xfer   = s_valid && s_ready;
    assign out_xfer  = m_valid_reg && m_ready;
    assign prev_zero = (prev_x_reg == '0) && (prev_y_reg == '0) && (prev_z_reg == '0);

    // one partial product row per cycle for each square
    assign pp_x = mx_reg[POS_W-1] ? {{POS_W{1'b0}}, ax_reg} : '0;
    assign pp_y = my_reg[POS_W-1] ? {{POS_W{1'b0}}, ay_reg} : '0;

    // square root: bring down two radicand bits, try root*4 + 1
    assign rem_sh = {rem_reg, acc_reg[SQ_W-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    // step count remainder: one dividend bit per cycle
    assign mod_sh = {mod_reg, sc_sh_reg[INTERVAL_W-1]};

    assign sum  = {1'b0, total_reg} + {{(MILEAGE_W-POS_W+1){1'b0}}, root_reg};
    assign save = (mod_reg == '0);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg;
        out_next      = out_reg;
        prev_x_next   = prev_x_reg;
        prev_y_next   = prev_y_reg;
        prev_z_next   = prev_z_reg;
        total_next    = total_reg;
        step_cnt_next = step_cnt_reg;
        save_int_next = save_int_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        mx_next       = mx_reg;
        my_next       = my_reg;
        acc_next      = acc_reg;
        root_next     = root_reg;
        rem_next      = rem_reg;
        sc_sh_next    = sc_sh_reg;
        div_next      = div_reg;
        mod_next      = mod_reg;

        if (out_xfer) begin
            m_valid_next = 1'b0;
        end

        // the user must send register writes only while the block is idle; the block does not enforce it
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SAVE_PERIOD:    save_int_next = cfg_data[INTERVAL_W-1:0];
                CFG_START_DISTANCE: total_next    = cfg_data[MILEAGE_W-1:0];
                default:            ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    prev_x_next = s_data.pos_x;
                    prev_y_next = s_data.pos_y;
                    prev_z_next = s_data.pos_z;
                    if (!prev_zero) begin
                        ax_next    = sat_abs_diff(s_data.pos_x, prev_x_reg);
                        ay_next    = sat_abs_diff(s_data.pos_y, prev_y_reg);
                        mx_next    = sat_abs_diff(s_data.pos_x, prev_x_reg);
                        my_next    = sat_abs_diff(s_data.pos_y, prev_y_reg);
                        acc_next   = '0;
                        sc_sh_next = step_cnt_reg;
                        // an interval of zero behaves as one
                        div_next   = (save_int_reg == '0) ? INTERVAL_W'(1) : save_int_reg;
                        mod_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                acc_next = {acc_reg[SQ_W-2:0], 1'b0} + pp_x + pp_y;
                mx_next  = {mx_reg[POS_W-2:0], 1'b0};
                my_next  = {my_reg[POS_W-2:0], 1'b0};
                if (cnt_reg < CNT_W'(INTERVAL_W)) begin
                    sc_sh_next = {sc_sh_reg[INTERVAL_W-2:0], 1'b0};
                    if (mod_sh >= {1'b0, div_reg}) begin
                        mod_next = INTERVAL_W'(mod_sh - {1'b0, div_reg});
                    end else begin
                        mod_next = mod_sh[INTERVAL_W-1:0];
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1) begin
                    root_next  = '0;
                    rem_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                acc_next = {acc_reg[SQ_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_next  = REM_W'(rem_sh - trial);
                    root_next = {root_reg[POS_W-2:0], 1'b1};
                end else begin
                    rem_next  = rem_sh[REM_W-1:0];
                    root_next = {root_reg[POS_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                // hold here while an earlier result is still untaken
                if (!m_valid_reg || m_ready) begin
                    total_next        = sum[MILEAGE_W] ? '1 : sum[MILEAGE_W-1:0];
                    out_next.mileage  = sum[MILEAGE_W] ? '1 : sum[MILEAGE_W-1:0];
                    out_next.save_now = save;
                    m_valid_next      = 1'b1;
                    step_cnt_next     = save ? INTERVAL_W'(1) : step_cnt_reg + 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            prev_z_reg   <= '0;
            total_reg    <= '0;
            step_cnt_reg <= STEP_COUNT_RST;
            save_int_reg <= SAVE_PERIOD_RST;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
            prev_x_reg   <= prev_x_next;
            prev_y_reg   <= prev_y_next;
            prev_z_reg   <= prev_z_next;
            total_reg    <= total_next;
            step_cnt_reg <= step_cnt_next;
            save_int_reg <= save_int_next;
        end
        out_reg   <= out_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        acc_reg   <= acc_next;
        root_reg  <= root_next;
        rem_reg   <= rem_next;
        sc_sh_reg <= sc_sh_next;
        div_reg   <= div_next;
        mod_reg   <= mod_next;
    end

`ifndef SYNTHESIS
    // a counted sample starts the squaring phase
    a_counted_starts_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && !prev_zero) |=> (state_reg == ST_MUL))
        else $error("counted sample did not start squaring");

    // a sample taken over an all-zero last position yields no result
    a_first_sample_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && prev_zero) |=> (state_reg == ST_IDLE && !$rose(m_valid_reg)))
        else $error("first sample produced a result");

    // root digit loop keeps the remainder within twice the partial root
    a_sqrt_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQRT || state_reg == ST_ACC)
            |-> ({1'b0, rem_reg} <= {2'b00, root_reg, 1'b0}))
        else $error("square root remainder out of range");

    // a save request restarts the step count
    a_save_restarts_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(state_reg) == ST_ACC && state_reg == ST_IDLE && out_reg.save_now)
            |-> (step_cnt_reg == STEP_COUNT_RST))
        else $error("step count not restarted after save");

    // results only come out of the accumulate step
    a_result_from_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_ACC))
        else $error("result raised outside accumulate step");
`endif

endmodule

`default_nettype wire
